// ===== rtl/core/dss_pkg.sv =====
package dss_pkg;

    localparam int SIEVE_LIMIT = 65536;
    localparam int PRIME_COUNT = 6542;

    localparam int NUM_W    = 31;
    localparam int SUM_W    = 34;
    localparam int S_DATA_W = ((NUM_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((SUM_W + 7) / 8) * 8;

    localparam int MARK_AW  = $clog2(SIEVE_LIMIT);
    localparam int SCAN_W   = $clog2(SIEVE_LIMIT + 1);
    localparam int PIDX_W   = $clog2(PRIME_COUNT);
    localparam int PCNT_W   = $clog2(PRIME_COUNT + 1);
    localparam int PRIME_W  = 16;
    localparam int TERM_W   = NUM_W + 1;
    localparam int BIT_W    = $clog2(TERM_W);

    typedef enum logic [4:0] {
        ST_CLR,
        ST_MARK_RD,
        ST_MARK_CHK,
        ST_MARK_WR,
        ST_COL_RD,
        ST_COL_CHK,
        ST_IDLE,
        ST_F_RD,
        ST_F_SQ,
        ST_F_CMP,
        ST_F_DIV,
        ST_F_DEND,
        ST_F_POW,
        ST_F_INC,
        ST_F_TAIL,
        ST_F_MUL,
        ST_OUT
    } t_state;

endpackage

// ===== rtl/core/divisor_sum_sigma_top.sv =====
// Per stored prime p with p*p <= n: one read, a square, a bit-serial restoring divide;
//   then one more divide per extra factor found and a bit-serial product update per
//   prime factor. One item at a time: the shared bit-serial divider and multiplier
//   take no new number until the last result is in the output register.
// Reset (synchronous, active low): clears the 65536-bit sieve map, marks
//   composites and collects primes; no beat accepted meanwhile.
module divisor_sum_sigma_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [dss_pkg::S_DATA_W-1:0]  i_s_tdata,   // [30:0] number
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [dss_pkg::M_DATA_W-1:0]  o_m_tdata    // [33:0] divisor_sum
);
    import dss_pkg::*;

    t_state r_state, n_state;

    logic [SCAN_W-1:0]  r_i, n_i, r_j, n_j;
    logic [PCNT_W-1:0]  r_cnt, n_cnt, r_k, n_k;
    logic [NUM_W-1:0]   r_n, n_n, r_dq, n_dq, r_pow, n_pow;
    logic [PRIME_W-1:0] r_p, n_p, r_rem, n_rem;
    logic [TERM_W-1:0]  r_sq, n_sq, r_term, n_term, r_mb, n_mb;
    logic [BIT_W-1:0]   r_bit, n_bit;
    logic               r_found, n_found, r_tail, n_tail, r_ov, n_ov;
    logic [SUM_W-1:0]   r_prod, n_prod, r_acc, n_acc, r_ma, n_ma, r_res, n_res;

    // sieve map and prime store
    logic               r_mark [SIEVE_LIMIT];
    logic               r_mrd;
    logic               m_we, m_wdata;
    logic [MARK_AW-1:0] m_addr;
    logic [PRIME_W-1:0] r_prime [PRIME_COUNT];
    logic [PRIME_W-1:0] r_prd;
    logic               p_we;
    logic [PIDX_W-1:0]  p_addr;

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            r_mark[m_addr] <= m_wdata;
        end
        r_mrd <= r_mark[m_addr];
    end

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            r_prime[p_addr] <= r_i[PRIME_W-1:0];
        end
        r_prd <= r_prime[p_addr];
    end

    logic [2*SCAN_W-1:0]      ii;
    logic [NUM_W+PRIME_W-1:0] pw;
    logic [PRIME_W:0]         rs, diff;
    logic                     ge;
    logic [SUM_W-1:0]         msum;

    assign ii   = r_i * r_i;
    assign pw   = r_pow * r_p;
    assign rs   = {r_rem, r_dq[NUM_W-1]};
    assign ge   = rs >= {1'b0, r_p};
    assign diff = rs - {1'b0, r_p};
    assign msum = r_acc + r_ma;

    always_comb begin
        n_state = r_state;
        n_i = r_i;   n_j = r_j;   n_cnt = r_cnt; n_k = r_k;
        n_n = r_n;   n_dq = r_dq; n_pow = r_pow; n_p = r_p; n_rem = r_rem;
        n_sq = r_sq; n_term = r_term; n_mb = r_mb; n_bit = r_bit;
        n_found = r_found; n_tail = r_tail; n_ov = r_ov;
        n_prod = r_prod; n_acc = r_acc; n_ma = r_ma; n_res = r_res;
        m_we = 1'b0; m_wdata = 1'b0; m_addr = r_i[MARK_AW-1:0];
        p_we = 1'b0; p_addr = r_k[PIDX_W-1:0];

        if (o_m_tvalid && i_m_tready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            ST_CLR: begin
                m_we = 1'b1;
                n_i  = r_i + 1'b1;
                if (r_i == SCAN_W'(SIEVE_LIMIT - 1)) begin
                    n_i     = SCAN_W'(2);
                    n_state = ST_MARK_RD;
                end
            end
            ST_MARK_RD: begin
                if (ii >= (2*SCAN_W)'(SIEVE_LIMIT)) begin
                    n_i     = SCAN_W'(2);
                    n_cnt   = '0;
                    n_state = ST_COL_RD;
                end else begin
                    n_state = ST_MARK_CHK;
                end
            end
            ST_MARK_CHK: begin
                if (!r_mrd) begin
                    n_j     = ii[SCAN_W-1:0];
                    n_state = ST_MARK_WR;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_MARK_RD;
                end
            end
            ST_MARK_WR: begin
                if (r_j < SCAN_W'(SIEVE_LIMIT)) begin
                    m_we    = 1'b1;
                    m_wdata = 1'b1;
                    m_addr  = r_j[MARK_AW-1:0];
                    n_j     = r_j + r_i;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_MARK_RD;
                end
            end
            ST_COL_RD: begin
                if (r_i == SCAN_W'(SIEVE_LIMIT) || r_cnt == PCNT_W'(PRIME_COUNT)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_COL_CHK;
                end
            end
            ST_COL_CHK: begin
                p_addr = r_cnt[PIDX_W-1:0];
                if (!r_mrd) begin
                    p_we  = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end
                n_i     = r_i + 1'b1;
                n_state = ST_COL_RD;
            end
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_n    = i_s_tdata[NUM_W-1:0];
                    n_prod = SUM_W'(1);
                    n_k    = '0;
                    if (i_s_tdata[NUM_W-1:0] == '0) begin
                        n_prod  = '0;
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_F_RD;
                    end
                end
            end
            ST_F_RD: begin
                n_state = (r_k == r_cnt) ? ST_F_TAIL : ST_F_SQ;
            end
            ST_F_SQ: begin
                n_p     = r_prd;
                n_sq    = TERM_W'(r_prd) * TERM_W'(r_prd);
                n_state = ST_F_CMP;
            end
            ST_F_CMP: begin
                if (r_p < PRIME_W'(2) || r_sq > {1'b0, r_n}) begin
                    n_state = ST_F_TAIL;
                end else begin
                    n_term  = TERM_W'(1);
                    n_pow   = NUM_W'(1);
                    n_found = 1'b0;
                    n_dq    = r_n;
                    n_rem   = '0;
                    n_bit   = '0;
                    n_state = ST_F_DIV;
                end
            end
            ST_F_DIV: begin
                n_rem = ge ? diff[PRIME_W-1:0] : rs[PRIME_W-1:0];
                n_dq  = {r_dq[NUM_W-2:0], ge};
                n_bit = r_bit + 1'b1;
                if (r_bit == BIT_W'(NUM_W - 1)) begin
                    n_state = ST_F_DEND;
                end
            end
            ST_F_DEND: begin
                if (r_rem == '0) begin
                    n_n     = r_dq;
                    n_pow   = pw[NUM_W-1:0];
                    n_state = ST_F_POW;
                end else if (r_found) begin
                    n_acc   = '0;
                    n_ma    = r_prod;
                    n_mb    = r_term;
                    n_bit   = '0;
                    n_tail  = 1'b0;
                    n_state = ST_F_MUL;
                end else begin
                    n_state = ST_F_INC;
                end
            end
            ST_F_POW: begin
                n_term  = r_term + {1'b0, r_pow};
                n_found = 1'b1;
                n_dq    = r_n;
                n_rem   = '0;
                n_bit   = '0;
                n_state = ST_F_DIV;
            end
            ST_F_INC: begin
                n_k     = r_k + 1'b1;
                n_state = ST_F_RD;
            end
            ST_F_TAIL: begin
                if (r_n > NUM_W'(1)) begin
                    n_acc   = '0;
                    n_ma    = r_prod;
                    n_mb    = {1'b0, r_n} + TERM_W'(1);
                    n_bit   = '0;
                    n_tail  = 1'b1;
                    n_state = ST_F_MUL;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_F_MUL: begin
                // shift-add, one multiplier bit per cycle, product kept mod 2^34
                n_acc = r_mb[0] ? msum : r_acc;
                n_ma  = {r_ma[SUM_W-2:0], 1'b0};
                n_mb  = {1'b0, r_mb[TERM_W-1:1]};
                n_bit = r_bit + 1'b1;
                if (r_bit == BIT_W'(TERM_W - 1)) begin
                    n_prod  = r_mb[0] ? msum : r_acc;
                    n_state = r_tail ? ST_OUT : ST_F_INC;
                end
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!r_ov || i_m_tready) begin
                    n_res   = r_prod;
                    n_ov    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_i     <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j <= n_j;     r_k <= n_k;       r_n <= n_n;       r_dq <= n_dq;
        r_pow <= n_pow; r_p <= n_p;       r_rem <= n_rem;   r_sq <= n_sq;
        r_term <= n_term; r_mb <= n_mb;   r_bit <= n_bit;   r_found <= n_found;
        r_tail <= n_tail; r_prod <= n_prod; r_acc <= n_acc; r_ma <= n_ma;
        r_res <= n_res;
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = M_DATA_W'(r_res);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted on back-to-back cycles");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_F_DIV) |-> (r_rem < r_p))
        else $error("divider remainder not below prime");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= PCNT_W'(PRIME_COUNT))
        else $error("prime count past store depth");

endmodule

// ===== tb/sv/tb_divisor_sum_sigma_top.sv =====
module tb_divisor_sum_sigma_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dss_pkg::*;

    localparam int N_RANDOM = 100;
    localparam int HOLD_OFF = 3000;

    typedef struct {
        logic [NUM_W-1:0] number;
        bit               typed;
        logic [SUM_W-1:0] sum;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata = '0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;

    logic [SUM_W-1:0] sum_queue[$];
    bit               plan_typed[$];
    logic [SUM_W-1:0] plan_sum[$];
    int               n_errors = 0;
    int               n_sent = 0;
    int               n_checked = 0;
    bit               sending_done = 1'b0;
    t_row             rows[$];

    divisor_sum_sigma_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // [30:0] number
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)    // [33:0] divisor_sum
    );

    always #10 i_clk = ~i_clk;

    // Trial division by every integer gives the same sigma as the prime table,
    // since the stored primes reach past sqrt of any 31-bit number.
    function automatic logic [SUM_W-1:0] divisor_sum(input logic [NUM_W-1:0] number);
        longint unsigned rest;
        longint unsigned prod;
        longint unsigned term;
        longint unsigned power;
        longint unsigned d;
        rest = number;
        prod = 1;
        if (rest == 0) begin
            return '0;
        end
        for (d = 2; d * d <= rest; d++) begin
            if (rest % d == 0) begin
                term  = 1;
                power = 1;
                while (rest % d == 0) begin
                    rest  = rest / d;
                    power = power * d;
                    term  = term + power;
                end
                prod = prod * term;
            end
        end
        if (rest > 1) begin
            prod = prod * (rest + 1);
        end
        return prod[SUM_W-1:0];
    endfunction

    task automatic report(input string what, input logic [SUM_W-1:0] got,
                          input logic [SUM_W-1:0] want);
        n_errors++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Monitor: record accepted inputs, check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            if (plan_typed.size() == 0) begin
                sum_queue.push_back(divisor_sum(i_s_tdata[NUM_W-1:0]));
            end else begin
                if (plan_typed.pop_front()) begin
                    sum_queue.push_back(plan_sum.pop_front());
                end else begin
                    void'(plan_sum.pop_front());
                    sum_queue.push_back(divisor_sum(i_s_tdata[NUM_W-1:0]));
                end
            end
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (sum_queue.size() == 0) begin
                report("unexpected beat", o_m_tdata[SUM_W-1:0], '0);
            end else begin
                logic [SUM_W-1:0] want;
                want = sum_queue.pop_front();
                n_checked++;
                if (o_m_tdata[SUM_W-1:0] !== want) begin
                    report("divisor_sum", o_m_tdata[SUM_W-1:0], want);
                end
            end
        end
    end

    // Receiver: random stalls, a calm window, and one long hold-off
    initial begin
        int  hold;
        bit  held;
        hold = 0;
        held = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && n_sent >= 50) begin
                held = 1'b1;
                hold = HOLD_OFF;
            end
            if (hold > 0) begin
                hold--;
                i_m_tready = 1'b0;
            end else if (n_sent >= 20 && n_sent < 45) begin
                i_m_tready = 1'b1;
            end else begin
                i_m_tready = ($urandom_range(99) >= 15);
            end
        end
    end

    task automatic send(input logic [NUM_W-1:0] number, input bit typed,
                        input logic [SUM_W-1:0] sum);
        bit calm;
        calm = (n_sent >= 20 && n_sent < 45);
        while (!calm && $urandom_range(99) < 15) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        plan_typed.push_back(typed);
        plan_sum.push_back(sum);
        i_s_tvalid = 1'b1;
        i_s_tdata  = '0;
        i_s_tdata[NUM_W-1:0] = number;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        n_sent++;
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    function automatic t_row mk(input logic [NUM_W-1:0] number, input bit typed,
                                input logic [SUM_W-1:0] sum);
        t_row r;
        r.number = number;
        r.typed  = typed;
        r.sum    = sum;
        return r;
    endfunction

    initial begin
        logic [NUM_W-1:0] v;
        int               waited;
        rows.push_back(mk(31'd1, 1'b1, 34'd1));
        rows.push_back(mk(31'd0, 1'b1, 34'd0));          // zero input has no divisors
        rows.push_back(mk(31'd2, 1'b1, 34'd3));
        rows.push_back(mk(31'd4, 1'b1, 34'd7));
        rows.push_back(mk(31'd12, 1'b1, 34'd28));
        rows.push_back(mk(31'h4000_0000, 1'b1, 34'h7FFF_FFFF));
        rows.push_back(mk(31'h7FFF_FFFF, 1'b1, 34'h8000_0000));  // largest, prime
        rows.push_back(mk(31'h7FFF_FFFE, 1'b0, '0));
        rows.push_back(mk(31'd65521, 1'b0, '0));        // largest stored prime
        rows.push_back(mk(31'd2147117569, 1'b0, '0));   // square of a prime near sqrt
        rows.push_back(mk(31'd720720, 1'b0, '0));       // many small factors
        rows.push_back(mk(31'd65536, 1'b1, 34'd131071));
        rows.push_back(mk(31'd1_073_741_823, 1'b0, '0));
        rows.push_back(mk(31'h5555_5555, 1'b0, '0));
        rows.push_back(mk(31'h2AAA_AAAA, 1'b0, '0));

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[k]) send(rows[k].number, rows[k].typed, rows[k].sum);

        // Most numbers stay small; shifted ones reach the high bits quickly
        for (int k = 0; k < N_RANDOM; k++) begin
            if ($urandom_range(99) < 70) begin
                v = NUM_W'($urandom_range(65535, 1));
            end else begin
                v = NUM_W'($urandom_range(65535, 1)) << $urandom_range(30, 0);
                if (v == 0) v = NUM_W'($urandom_range(65535, 1)) | 31'h4000_0000;
            end
            send(v, 1'b0, '0);
        end
        sending_done = 1'b1;

        waited = 0;
        while (sum_queue.size() != 0 && waited < 1_000_000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (200) @(posedge i_clk);
        $display("Covered %0d numbers: directed edge values, powers of two, large primes,",
                 n_sent);
        $display("random small and shifted values; %0d sums checked.", n_checked);
        if (n_errors == 0 && sum_queue.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #(64'd200_000_000);
        $display("TIMEOUT after %0d beats sent", n_sent);
        $display("simulation failed");
        $finish;
    end

endmodule
